// ===== sv/sm3_pkg.sv =====
// Package: SM3 engine types, constants and helper functions.
`default_nettype none
package sm3_pkg;

  localparam logic [31:0] IV0 = 32'h7380166f;
  localparam logic [31:0] IV1 = 32'h4914b2b9;
  localparam logic [31:0] IV2 = 32'h172442d7;
  localparam logic [31:0] IV3 = 32'hda8a0600;
  localparam logic [31:0] IV4 = 32'ha96f30bc;
  localparam logic [31:0] IV5 = 32'h163138aa;
  localparam logic [31:0] IV6 = 32'he38dee4d;
  localparam logic [31:0] IV7 = 32'hb0fb0e4e;
  localparam logic [31:0] T_LO = 32'h79CC4519;
  localparam logic [31:0] T_HI = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item
    ST_ROUND,  // 64 rounds on a full block
    ST_PAD,    // pad block being built
    ST_OUT     // fold, then next pad block or digest capture
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic absorb;      // take input item bytes
    logic start_pad;   // capture total length, append 0x80 and zeros
    logic fill_pad;    // fill the rest of the current pad block
    logic start_comp;  // load working regs and schedule
    logic round;       // run one round
    logic finish_comp; // fold working regs into chaining value
    logic load_out;    // capture digest and reset state
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic block_full;  // 64 bytes are held
    logic last_round;  // round counter at 63
    logic pad_last;    // pad block carries the length
  } sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

// ===== sv/sm3_datapath.sv =====
// Datapath: block buffer, schedule window, round logic and chaining value.
`default_nettype none
module sm3_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sm3_pkg::cmd_t cmd_i,
  output sm3_pkg::sts_t      sts_o,
  input  wire logic [31:0]   data_word_i,
  input  wire logic [2:0]    byte_count_i,
  output logic [255:0]       digest_o
);
  import sm3_pkg::*;

  // Block buffer as 16 big-endian words, byte 0 in bits 31..24 of word 0
  logic [31:0] buf_q [16];
  logic [31:0] buf_d [16];
  // Bytes of an item that run past the end of a full block
  logic [31:0] carry_q, carry_d;
  logic [6:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [63:0] total_q, total_d;
  logic        pad_last_q, pad_last_d;
  logic [31:0] cv_q [8];
  logic [31:0] cv_d [8];
  logic [31:0] wk_q [8];
  logic [31:0] wk_d [8];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [5:0]  rnd_q, rnd_d;
  logic [255:0] dig_q, dig_d;

  logic [2:0]  cnt;
  logic [6:0]  bpos;
  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;

  // Round function and next schedule word
  always_comb begin
    tj  = (rnd_q < 6'd16) ? T_LO : T_HI;
    a12 = rotl(wk_q[0], 5'd12);
    ss1 = rotl(a12 + wk_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_q < 6'd16) begin
      ff = wk_q[0] ^ wk_q[1] ^ wk_q[2];
      gg = wk_q[4] ^ wk_q[5] ^ wk_q[6];
    end else begin
      ff = (wk_q[0] & wk_q[1]) | (wk_q[0] & wk_q[2]) | (wk_q[1] & wk_q[2]);
      gg = (wk_q[4] & wk_q[5]) | (~wk_q[4] & wk_q[6]);
    end
    tt1 = ff + wk_q[3] + ss2 + (w_q[0] ^ w_q[4]);
    tt2 = gg + wk_q[7] + ss1 + w_q[0];
    wnew = p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
  end

  // Next-state logic for all datapath registers
  always_comb begin
    buf_d      = buf_q;
    carry_d    = carry_q;
    fill_d     = fill_q;
    len_d      = len_q;
    total_d    = total_q;
    pad_last_d = pad_last_q;
    cv_d       = cv_q;
    wk_d       = wk_q;
    w_d        = w_q;
    rnd_d      = rnd_q;
    dig_d      = dig_q;
    bpos       = fill_q;
    cnt        = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;

    // Bytes past the block end go to the carry word
    if (cmd_i.absorb) begin
      for (int i = 0; i < 4; i++) begin
        bpos = fill_q + 7'(i);
        if (3'(i) < cnt) begin
          if (bpos[6]) begin
            carry_d[{~bpos[1:0], 3'b000} +: 8] = data_word_i[31-8*i -: 8];
          end else begin
            buf_d[bpos[5:2]][{~bpos[1:0], 3'b000} +: 8] = data_word_i[31-8*i -: 8];
          end
        end
      end
      fill_d = fill_q + 7'(cnt);
    end

    if (cmd_i.start_pad) begin
      total_d = len_q + {55'd0, fill_q[5:0], 3'd0};
      for (int i = 0; i < 64; i++) begin
        if (7'(i) > fill_q) buf_d[4'(i >> 2)][8*(3 - (i & 3)) +: 8] = 8'h00;
      end
      buf_d[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] = PAD_BYTE;
      pad_last_d = (fill_q < 7'd56);
      fill_d = 7'd64;
    end

    if (cmd_i.fill_pad) begin
      // Second pad block is zeros, or length goes into current block
      if (!pad_last_q) begin
        for (int i = 0; i < 16; i++) buf_d[4'(i)] = 32'd0;
      end
      buf_d[14] = total_q[63:32];
      buf_d[15] = total_q[31:0];
      fill_d = 7'd64;
    end

    // Load schedule and move any carried bytes to the block start
    if (cmd_i.start_comp) begin
      w_d    = buf_q;
      buf_d[0] = carry_q;
      wk_d   = cv_q;
      rnd_d  = 6'd0;
      fill_d = {1'b0, fill_q[5:0]};
    end

    if (cmd_i.round) begin
      wk_d[3] = wk_q[2];
      wk_d[2] = rotl(wk_q[1], 5'd9);
      wk_d[1] = wk_q[0];
      wk_d[0] = tt1;
      wk_d[7] = wk_q[6];
      wk_d[6] = rotl(wk_q[5], 5'd19);
      wk_d[5] = wk_q[4];
      wk_d[4] = p0(tt2);
      for (int j = 0; j < 15; j++) w_d[j] = w_q[j+1];
      w_d[15] = wnew;
      rnd_d = rnd_q + 6'd1;
    end

    if (cmd_i.finish_comp) begin
      for (int j = 0; j < 8; j++) cv_d[j] = cv_q[j] ^ wk_q[j];
      len_d = len_q + 64'd512;
    end

    // Fold the last block straight into the digest
    if (cmd_i.load_out) begin
      dig_d = {cv_q[0] ^ wk_q[0], cv_q[1] ^ wk_q[1], cv_q[2] ^ wk_q[2],
               cv_q[3] ^ wk_q[3], cv_q[4] ^ wk_q[4], cv_q[5] ^ wk_q[5],
               cv_q[6] ^ wk_q[6], cv_q[7] ^ wk_q[7]};
      cv_d  = '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
      len_d = 64'd0;
      fill_d = 7'd0;
    end
  end

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 7'd0;
      len_q  <= 64'd0;
      cv_q   <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
      rnd_q  <= 6'd0;
    end else begin
      fill_q <= fill_d;
      len_q  <= len_d;
      cv_q   <= cv_d;
      rnd_q  <= rnd_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    carry_q    <= carry_d;
    total_q    <= total_d;
    pad_last_q <= pad_last_d;
    wk_q       <= wk_d;
    w_q        <= w_d;
    dig_q      <= dig_d;
  end

  assign sts_o.block_full = fill_q[6];
  assign sts_o.last_round = (rnd_q == 6'd63);
  assign sts_o.pad_last   = pad_last_q;
  assign digest_o         = dig_q;

endmodule
`default_nettype wire

// ===== sv/sm3_ctrl.sv =====
// Controller: sequences absorb, compression, padding and digest output.
`default_nettype none
module sm3_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_fire_i,
  input  wire logic          in_final_i,
  input  wire logic          out_ready_i,
  input  wire sm3_pkg::sts_t sts_i,
  output sm3_pkg::cmd_t      cmd_o,
  output logic               in_ready_o,
  output logic               out_valid_o
);
  import sm3_pkg::*;

  // Padding phases
  localparam logic [1:0] PH_DATA  = 2'd0;  // no padding
  localparam logic [1:0] PH_PAD   = 2'd1;  // final item taken, pad block pending
  localparam logic [1:0] PH_EXTRA = 2'd2;  // zero block with length still to come
  localparam logic [1:0] PH_LAST  = 2'd3;  // last block, then digest

  state_e state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_DATA;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.block_full) begin
          cmd_o.start_comp = 1'b1;
          state_d = ST_ROUND;
        end else if (phase_q != PH_DATA) begin
          cmd_o.start_pad = 1'b1;
          state_d = ST_PAD;
        end else begin
          in_ready_o = 1'b1;
          if (in_fire_i) begin
            cmd_o.absorb = 1'b1;
            if (in_final_i) phase_d = PH_PAD;
          end
        end
      end
      ST_PAD: begin
        if (sts_i.pad_last) begin
          cmd_o.fill_pad = 1'b1;
          phase_d = PH_LAST;
        end else begin
          phase_d = PH_EXTRA;
        end
        cmd_o.start_comp = 1'b0;
        state_d = ST_IDLE;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) state_d = ST_OUT;
      end
      ST_OUT: begin
        // fold result, then decide on next pad block or digest
        if (phase_q == PH_DATA || phase_q == PH_PAD) begin
          cmd_o.finish_comp = 1'b1;
          state_d = ST_IDLE;
        end else if (phase_q == PH_EXTRA) begin
          cmd_o.finish_comp = 1'b1;
          cmd_o.fill_pad = 1'b1;
          phase_d = PH_LAST;
          state_d = ST_IDLE;
        end else if (!out_valid_q) begin
          // hold here until the previous digest has left
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          phase_d = PH_DATA;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  default_in_ready_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE && phase_q == PH_DATA) else $error("ready outside idle");
  round_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.round |-> !in_ready_o) else $error("round overlaps input handshake");
  out_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("digest dropped");
  load_free_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !out_valid_o) else $error("digest overwritten");

endmodule
`default_nettype wire

// ===== sv/sm3_hash_engine_unit.sv =====
// Top level: SM3 hash engine with stream input and digest output.
//   channel | dir | handshake             | payload
//   s_axis  | in  | s_axis_tvalid/tready  | tdata{byte_count,data_word}, tlast=final_item
//   m_axis  | out | m_axis_tvalid/tready  | tdata{part0..part3}
// One 32-bit item is taken per cycle while a block fills; a full block then
// runs start, 64 rounds of the single round unit and fold, and no items are
// taken meanwhile. A final item leads to a pad build, then to one or two
// padded blocks, each compressed the same way.
// Reset restores the initial vector and an empty buffer; the digest waits
// in its register until m_axis_tready is high, and the next message stalls
// at its last fold only if the previous digest is still waiting.
`default_nettype none
module sm3_hash_engine_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [39:0]  s_axis_tdata,  // data_word[31:0], byte_count[34:32], zero
  input  wire logic         s_axis_tlast,  // final_item
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [255:0]      m_axis_tdata   // digest_part0..digest_part3 from low bits
);
  import sm3_pkg::*;

  cmd_t         cmd;
  sts_t         sts;
  logic [255:0] dig;

  sm3_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_fire_i(s_axis_tvalid && s_axis_tready), .in_final_i(s_axis_tlast),
    .out_ready_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  sm3_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .sts_o(sts),
    .data_word_i(s_axis_tdata[31:0]), .byte_count_i(s_axis_tdata[34:32]),
    .digest_o(dig)
  );

  // Pack digest, part0 in the low bits
  assign m_axis_tdata = {dig[63:0], dig[127:64], dig[191:128], dig[255:192]};

endmodule
`default_nettype wire

// ===== tb/tb_sm3_hash_engine_unit.sv =====
// Testbench for sm3_hash_engine_unit: random messages checked against an SM3 digest predictor.
`default_nettype none
module tb_sm3_hash_engine_unit;
  import sm3_pkg::*;

  localparam int ITEM_GOAL = 1800;

  // Running SM3 digest predictor and queue of digests still owed by the block
  class sm3_digest_board;
    logic [31:0]  chain[8];
    logic [7:0]   blk_bytes[64];
    int unsigned  fill;
    logic [63:0]  bit_len;
    logic [255:0] owed_digests[$];
    int unsigned  digests_seen;

    function new();
      clear();
    endfunction

    function void clear();
      chain = '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
      foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
      fill = 0;
      bit_len = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w[68];
      logic [31:0] a, b, c, d, e, f, g, h, k, a12, ss1, ss2, ff, gg, tt1, tt2;
      for (int j = 0; j < 16; j++)
        w[j] = {blk_bytes[4*j], blk_bytes[4*j+1], blk_bytes[4*j+2], blk_bytes[4*j+3]};
      for (int j = 16; j < 68; j++) begin
        k = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
        w[j] = (k ^ rol(k, 15) ^ rol(k, 23)) ^ rol(w[j-13], 7) ^ w[j-6];
      end
      {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                  chain[4], chain[5], chain[6], chain[7]};
      for (int j = 0; j < 64; j++) begin
        k = (j < 16) ? T_LO : T_HI;
        a12 = rol(a, 12);
        ss1 = rol(a12 + e + rol(k, j), 7);
        ss2 = ss1 ^ a12;
        if (j < 16) begin
          ff = a ^ b ^ c;
          gg = e ^ f ^ g;
        end else begin
          ff = (a & b) | (a & c) | (b & c);
          gg = (e & f) | (~e & g);
        end
        tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
        tt2 = gg + h + ss1 + w[j];
        d = c;
        c = rol(b, 9);
        b = a;
        a = tt1;
        h = g;
        g = rol(f, 19);
        f = e;
        e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endfunction

    function void absorb(logic [7:0] v);
      blk_bytes[fill] = v;
      fill++;
      if (fill == 64) begin
        compress();
        bit_len += 64'd512;
        fill = 0;
      end
    endfunction

    // Note one accepted item; a final item queues the digest it produces
    function void note_item(logic [31:0] word, logic [2:0] cnt, logic last);
      int unsigned n, padn;
      logic [63:0] total;
      logic [255:0] dg;
      n = (cnt > 3'd4) ? 4 : cnt;
      for (int i = 0; i < n; i++) absorb(word[31-8*i -: 8]);
      if (!last) return;
      total = bit_len + 64'(fill * 8);
      padn = (fill + 1 <= 56) ? (56 - fill) : (120 - fill);
      absorb(PAD_BYTE);
      for (int i = 1; i < padn; i++) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(total[63-8*i -: 8]);
      for (int i = 0; i < 4; i++) dg[64*i +: 64] = {chain[2*i], chain[2*i+1]};
      owed_digests.push_back(dg);
      clear();
    endfunction

    // Compare a delivered digest with the oldest one owed; why lists bad fields
    function bit check_digest(logic [255:0] got, output string why);
      logic [255:0] want;
      why = "";
      digests_seen++;
      if (owed_digests.size() == 0) begin
        why = $sformatf("digest %h with none pending", got);
        return 0;
      end
      want = owed_digests.pop_front();
      for (int i = 0; i < 4; i++)
        if (got[64*i +: 64] !== want[64*i +: 64])
          why = {why, $sformatf("digest_part%0d got %h want %h; ", i,
                                got[64*i +: 64], want[64*i +: 64])};
      return why == "";
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;   // data_word[31:0], byte_count[34:32], zero
  logic         s_axis_tlast = 1'b0; // final_item
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;        // digest_part0..digest_part3 from low bits

  sm3_digest_board board;
  int  errors = 0;
  int  items_sent = 0;
  int  messages_sent = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;

  sm3_hash_engine_unit u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Offer one item, with random gaps ahead of it, and wait until it is taken
  task automatic send_item(logic [31:0] word, logic [2:0] cnt, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, cnt, word};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(word, cnt, last);
    items_sent++;
    if (last) messages_sent++;
  endtask

  // Send a message of nbytes bytes; some non-final items are short
  task automatic send_message(int nbytes);
    int left, n;
    logic [31:0] word;
    logic [2:0] cnt;
    left = nbytes;
    while (left > 4 || (left == 4 && $urandom_range(1))) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(3) : 4;
      word = $urandom;
      cnt = (n == 4 && $urandom_range(15) == 0) ? 3'($urandom_range(7, 5)) : 3'(n);
      send_item(word, cnt, 1'b0);
      left -= n;
    end
    cnt = (left == 4 && $urandom_range(3) == 0) ? 3'($urandom_range(7, 5)) : 3'(left);
    send_item($urandom, cnt, 1'b1);
  endtask

  // Receiver: random stalls, plus one long hold when asked
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = 600;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check each delivered digest
  always @(posedge clk_i) begin
    string why;
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      if (!board.check_digest(m_axis_tdata, why)) report(why);
  end

  // Stimulus and end of run
  initial begin
    int guard;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 9;
    recv_idle_pct = 69;
    // Empty message, then the three-byte message "abc"
    send_item(32'hDEAD_BEEF, 3'd0, 1'b1);
    send_item(32'h6162_63FF, 3'd3, 1'b1);
    // Short non-final items and byte counts above four
    send_item(32'hFFFF_FFFF, 3'd1, 1'b0);
    send_item(32'h0000_0000, 3'd2, 1'b0);
    send_item(32'hA5A5_A5A5, 3'd3, 1'b0);
    send_item(32'h1234_5678, 3'd0, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd5, 1'b0);
    send_item(32'h0000_0000, 3'd6, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd7, 1'b1);
    send_item(32'h8000_0001, 3'd4, 1'b1);

    // Long receiver hold while the sender keeps offering items
    hold_req = 1'b1;
    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= 2 * ITEM_GOAL / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= ITEM_GOAL / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 9;
      end
      send_message(($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(130));
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (board.owed_digests.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    if (board.owed_digests.size() != 0)
      report($sformatf("%0d digests never delivered", board.owed_digests.size()));
    repeat (300) @(posedge clk_i);
    $display("Covered %0d items in %0d messages, %0d digests checked,", items_sent,
             messages_sent, board.digests_seen);
    $display("with short items, oversize byte counts and a long output hold.");
    if (errors == 0) begin
      $display("tb_sm3_hash_engine_unit passed");
    end else begin
      $display("tb_sm3_hash_engine_unit failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout at %0t", $time);
    $display("tb_sm3_hash_engine_unit failed");
    $finish;
  end

endmodule
`default_nettype wire
